// ===== rtl/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types, constants and lookup functions for the report decoder.
// ----------------------------------------------------------------------------
package crd_pkg;

    localparam int CNT_W   = 12;              // stick count and calibration width
    localparam int QUO_W   = 15;              // quotient bits below the clamp
    localparam int NUM_W   = CNT_W + QUO_W;   // scaled numerator width
    localparam int BTN_W   = 11;
    localparam int BAT_W   = 7;
    localparam int AXIS_W  = 16;
    localparam int PREP_DEPTH = 2;
    localparam int LAT_CORE   = PREP_DEPTH + QUO_W;   // stages before output register
    localparam logic [15:0] MIN_BODY_LEN = 16'd11;
    localparam logic [QUO_W-1:0] FULL_SCALE = 15'd32767;

    // register indexes of the configuration port
    localparam logic [2:0] REG_RIGHT_SIDE = 3'd0;
    localparam logic [2:0] REG_X_CENTER   = 3'd1;
    localparam logic [2:0] REG_Y_CENTER   = 3'd2;
    localparam logic [2:0] REG_X_BELOW    = 3'd3;
    localparam logic [2:0] REG_X_ABOVE    = 3'd4;
    localparam logic [2:0] REG_Y_BELOW    = 3'd5;
    localparam logic [2:0] REG_Y_ABOVE    = 3'd6;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd7;

    typedef struct packed {
        logic neg;     // deflection below center
        logic zero;    // inside dead band
        logic clamp;   // quotient exceeds full scale
    } t_axis_tag;

    typedef struct packed {
        logic              accepted;
        logic [BTN_W-1:0]  buttons;
        logic [BAT_W-1:0]  battery;
        logic [31:0]       stamp;
    } t_side_band;

    function automatic logic [BAT_W-1:0] battery_lut(input logic [3:0] nib);
        logic [BAT_W-1:0] pct;
        case (nib)
            4'd0:    pct = 7'd5;
            4'd1:    pct = 7'd10;
            4'd2:    pct = 7'd25;
            4'd3:    pct = 7'd40;
            4'd4:    pct = 7'd50;
            4'd5:    pct = 7'd65;
            4'd6:    pct = 7'd75;
            4'd7:    pct = 7'd90;
            default: pct = 7'd100;
        endcase
        return pct;
    endfunction

    function automatic logic [BTN_W-1:0] pack_buttons(input logic right,
            input logic [7:0] rbtn, input logic [7:0] shared, input logic [7:0] lbtn);
        logic [BTN_W-1:0] b;
        if (right) begin
            b = {shared[4], shared[2], shared[1], rbtn[4], rbtn[5], rbtn[7], rbtn[6],
                 rbtn[0], rbtn[1], rbtn[2], rbtn[3]};
        end else begin
            b = {shared[5], shared[3], shared[0], lbtn[4], lbtn[5], lbtn[7], lbtn[6],
                 lbtn[2], lbtn[3], lbtn[0], lbtn[1]};
        end
        return b;
    endfunction

endpackage

// ===== rtl/crd_axis_prep.sv =====
// ----------------------------------------------------------------------------
// crd_axis_prep
// Two-stage front end of one axis: offset, dead band, span, numerator, clamp.
// ----------------------------------------------------------------------------
module crd_axis_prep
    import crd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [CNT_W-1:0]  i_raw,
    input  logic [CNT_W-1:0]  i_center,
    input  logic [CNT_W-1:0]  i_below,
    input  logic [CNT_W-1:0]  i_above,
    input  logic [CNT_W-1:0]  i_band,
    output logic              o_vld,
    output logic [NUM_W-1:0]  o_num,
    output logic [CNT_W-1:0]  o_den,
    output t_axis_tag         o_tag
);

    logic [CNT_W:0]   delta;
    logic             neg;
    logic [CNT_W-1:0] mag;
    logic [CNT_W-1:0] travel;
    logic [CNT_W-1:0] n_span;

    logic             r_v1;
    logic             r_neg1;
    logic             r_zero1;
    logic [CNT_W-1:0] r_d1;
    logic [CNT_W-1:0] r_span1;

    logic [NUM_W-1:0] num2;
    logic             r_v2;
    logic [NUM_W-1:0] r_num2;
    logic [CNT_W-1:0] r_den2;
    t_axis_tag        r_tag2;

    always_comb begin
        delta  = {1'b0, i_raw} - {1'b0, i_center};
        neg    = delta[CNT_W];
        mag    = neg ? CNT_W'(-delta) : delta[CNT_W-1:0];
        travel = neg ? i_below : i_above;
        if (travel == '0) begin
            travel = CNT_W'(1);
        end
        n_span = (travel > i_band) ? (travel - i_band) : CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
        r_neg1  <= neg;
        r_zero1 <= (mag <= i_band);
        r_d1    <= mag - i_band;
        r_span1 <= n_span;
    end

    // d * 32767 as d * 2^15 - d
    assign num2 = {r_d1, {QUO_W{1'b0}}} - NUM_W'(r_d1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_num2       <= num2;
        r_den2       <= r_span1;
        r_tag2.neg   <= r_neg1;
        r_tag2.zero  <= r_zero1;
        r_tag2.clamp <= (num2 >= {r_span1, {QUO_W{1'b0}}});
    end

    assign o_vld = r_v2;
    assign o_num = r_num2;
    assign o_den = r_den2;
    assign o_tag = r_tag2;

endmodule

// ===== rtl/crd_div.sv =====
// ----------------------------------------------------------------------------
// crd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module crd_div
    import crd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [CNT_W-1:0]  i_den,
    input  t_axis_tag         i_tag,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_quo,
    output t_axis_tag         o_tag
);

    logic              r_vld [QUO_W];
    logic [NUM_W-1:0]  r_rem [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];
    logic [CNT_W-1:0]  r_den [QUO_W];
    t_axis_tag         r_tag [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic              p_vld;
        logic [NUM_W-1:0]  p_rem;
        logic [QUO_W-1:0]  p_quo;
        logic [CNT_W-1:0]  p_den;
        t_axis_tag         p_tag;
        logic [NUM_W-1:0]  sub;
        logic              fits;

        if (s == 0) begin : g_first
            assign p_vld = i_vld;
            assign p_rem = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_vld = r_vld[s-1];
            assign p_rem = r_rem[s-1];
            assign p_quo = r_quo[s-1];
            assign p_den = r_den[s-1];
            assign p_tag = r_tag[s-1];
        end

        assign sub  = NUM_W'(p_den) << B;
        assign fits = (p_rem >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
            r_rem[s] <= fits ? (p_rem - sub) : p_rem;
            r_quo[s] <= p_quo | (QUO_W'(fits) << B);
            r_den[s] <= p_den;
            r_tag[s] <= p_tag;
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];
    assign o_tag = r_tag[QUO_W-1];

endmodule

// ===== rtl/controller_report_decode.sv =====
// ----------------------------------------------------------------------------
// controller_report_decode
// Decodes one controller input report per request into scaled sticks,
// side-specific buttons, battery percentage and a time stamp.
// ----------------------------------------------------------------------------
// Pipeline: a request passes through two axis front stages, the 15-stage divider
//   pipeline and the output register before it shows on the result ports
//   (o_valid high for one cycle).
// Throughput: one request per cycle; busy is never raised, since every stage
//   advances each cycle and the receiver cannot stall.
// Reset: synchronous, active low; clears all valid bits and loads the
//   calibration registers with their defaults.
// ----------------------------------------------------------------------------
module controller_report_decode
    import crd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              start,
    output logic              busy,
    input  logic [15:0]       i_body_length,
    input  logic [7:0]        i_status_byte,
    input  logic [7:0]        i_right_button_byte,
    input  logic [7:0]        i_shared_button_byte,
    input  logic [7:0]        i_left_button_byte,
    input  logic [23:0]       i_left_stick_bytes,
    input  logic [23:0]       i_right_stick_bytes,
    input  logic [31:0]       i_time_ms,
    // result channel
    output logic              o_valid,
    output logic              o_accepted,
    output logic signed [15:0] o_stick_x,
    output logic signed [15:0] o_stick_y,
    output logic [BTN_W-1:0]  o_button_bits,
    output logic [BAT_W-1:0]  o_battery_percent,
    output logic [31:0]       o_stamp_ms,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------------------------------------------------------- config
    logic             r_right_side;
    logic [CNT_W-1:0] r_x_center;
    logic [CNT_W-1:0] r_y_center;
    logic [CNT_W-1:0] r_x_below;
    logic [CNT_W-1:0] r_x_above;
    logic [CNT_W-1:0] r_y_below;
    logic [CNT_W-1:0] r_y_above;
    logic [CNT_W-1:0] r_dead_band;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_side <= 1'b0;
            r_x_center   <= 12'd2048;
            r_y_center   <= 12'd2048;
            r_x_below    <= 12'd1300;
            r_x_above    <= 12'd1300;
            r_y_below    <= 12'd1300;
            r_y_above    <= 12'd1300;
            r_dead_band  <= 12'd160;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RIGHT_SIDE: r_right_side <= pwdata[0];
                REG_X_CENTER:   r_x_center   <= pwdata[CNT_W-1:0];
                REG_Y_CENTER:   r_y_center   <= pwdata[CNT_W-1:0];
                REG_X_BELOW:    r_x_below    <= pwdata[CNT_W-1:0];
                REG_X_ABOVE:    r_x_above    <= pwdata[CNT_W-1:0];
                REG_Y_BELOW:    r_y_below    <= pwdata[CNT_W-1:0];
                REG_Y_ABOVE:    r_y_above    <= pwdata[CNT_W-1:0];
                REG_DEAD_BAND:  r_dead_band  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back the selected register
    always_comb begin
        case (reg_idx)
            REG_RIGHT_SIDE: prdata = {31'd0, r_right_side};
            REG_X_CENTER:   prdata = {20'd0, r_x_center};
            REG_Y_CENTER:   prdata = {20'd0, r_y_center};
            REG_X_BELOW:    prdata = {20'd0, r_x_below};
            REG_X_ABOVE:    prdata = {20'd0, r_x_above};
            REG_Y_BELOW:    prdata = {20'd0, r_y_below};
            REG_Y_ABOVE:    prdata = {20'd0, r_y_above};
            default:        prdata = {20'd0, r_dead_band};
        endcase
    end

    // --------------------------------------------------------------- request
    // Every cycle can take a request; nothing ever backs up.
    logic        take;
    logic [23:0] stick;

    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign stick = r_right_side ? i_right_stick_bytes : i_left_stick_bytes;

    // ------------------------------------------------------------ axis paths
    logic             x_pv, y_pv;
    logic [NUM_W-1:0] x_num, y_num;
    logic [CNT_W-1:0] x_den, y_den;
    t_axis_tag        x_ptag, y_ptag;
    logic             x_dv, y_dv;
    logic [QUO_W-1:0] x_quo, y_quo;
    t_axis_tag        x_tag, y_tag;

    crd_axis_prep u_prep_x (
        .i_clk, .i_rst_n, .i_vld(take),
        .i_raw(stick[CNT_W-1:0]), .i_center(r_x_center),
        .i_below(r_x_below), .i_above(r_x_above), .i_band(r_dead_band),
        .o_vld(x_pv), .o_num(x_num), .o_den(x_den), .o_tag(x_ptag)
    );

    crd_axis_prep u_prep_y (
        .i_clk, .i_rst_n, .i_vld(take),
        .i_raw(stick[2*CNT_W-1:CNT_W]), .i_center(r_y_center),
        .i_below(r_y_below), .i_above(r_y_above), .i_band(r_dead_band),
        .o_vld(y_pv), .o_num(y_num), .o_den(y_den), .o_tag(y_ptag)
    );

    crd_div u_div_x (
        .i_clk, .i_rst_n, .i_vld(x_pv), .i_num(x_num), .i_den(x_den), .i_tag(x_ptag),
        .o_vld(x_dv), .o_quo(x_quo), .o_tag(x_tag)
    );

    crd_div u_div_y (
        .i_clk, .i_rst_n, .i_vld(y_pv), .i_num(y_num), .i_den(y_den), .i_tag(y_ptag),
        .o_vld(y_dv), .o_quo(y_quo), .o_tag(y_tag)
    );

    // ---------------------------------------------------------- side band
    // Carry the fields that need no arithmetic alongside the axis pipes.
    t_side_band r_sb [LAT_CORE];
    t_side_band n_sb;

    always_comb begin
        n_sb.accepted = (i_body_length >= MIN_BODY_LEN);
        n_sb.buttons  = pack_buttons(r_right_side, i_right_button_byte,
                                     i_shared_button_byte, i_left_button_byte);
        n_sb.battery  = battery_lut(i_status_byte[7:4]);
        n_sb.stamp    = i_time_ms;
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_sb;
        for (int k = 1; k < LAT_CORE; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    // ---------------------------------------------------------- result stage
    function automatic logic [AXIS_W-1:0] finish_axis(input t_axis_tag tag,
                                                      input logic [QUO_W-1:0] quo);
        logic [AXIS_W-1:0] m;
        if (tag.zero) begin
            m = '0;
        end else begin
            m = AXIS_W'(tag.clamp ? FULL_SCALE : quo);
        end
        return tag.neg ? -m : m;
    endfunction

    logic              r_valid;
    logic              r_accepted;
    logic [AXIS_W-1:0] r_x;
    logic [AXIS_W-1:0] r_y;
    logic [BTN_W-1:0]  r_btn;
    logic [BAT_W-1:0]  r_bat;
    logic [31:0]       r_stamp;
    logic              acc;

    assign acc = r_sb[LAT_CORE-1].accepted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= x_dv && y_dv;
        end
        // short reports drop every field to zero
        r_accepted <= acc;
        r_x        <= acc ? finish_axis(x_tag, x_quo) : '0;
        r_y        <= acc ? finish_axis(y_tag, y_quo) : '0;
        r_btn      <= acc ? r_sb[LAT_CORE-1].buttons : '0;
        r_bat      <= acc ? r_sb[LAT_CORE-1].battery : '0;
        r_stamp    <= acc ? r_sb[LAT_CORE-1].stamp : '0;
    end

    assign o_valid           = r_valid;
    assign o_accepted        = r_accepted;
    assign o_stick_x         = r_x;
    assign o_stick_y         = r_y;
    assign o_button_bits     = r_btn;
    assign o_battery_percent = r_bat;
    assign o_stamp_ms        = r_stamp;

endmodule

// ===== rtl/crd_chk.sv =====
// ----------------------------------------------------------------------------
// crd_chk
// Port-level checks on the report decoder, bound to the top level.
// ----------------------------------------------------------------------------
module crd_chk
    import crd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              o_valid,
    input  logic              o_accepted,
    input  logic signed [15:0] o_stick_x,
    input  logic signed [15:0] o_stick_y,
    input  logic [BAT_W-1:0]  o_battery_percent,
    input  logic [31:0]       o_stamp_ms
);

    localparam int LAT = LAT_CORE + 1;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request did not produce a result on time");

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_stamp_ms == 32'd0 && o_stick_x == 16'sd0
                                      && o_battery_percent == 7'd0))
        else $error("rejected report carries nonzero fields");

    a_axis_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stick_x != -16'sd32768 && o_stick_y != -16'sd32768))
        else $error("stick outside full scale");

    a_battery : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_battery_percent >= 7'd5
                                     && o_battery_percent <= 7'd100))
        else $error("battery percentage out of table range");

endmodule

bind controller_report_decode crd_chk u_crd_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_accepted(o_accepted), .o_stick_x(o_stick_x),
    .o_stick_y(o_stick_y), .o_battery_percent(o_battery_percent),
    .o_stamp_ms(o_stamp_ms)
);
